// File: hdl/bbe_pkg.sv
package bbe_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int CFG_DATA_W  = 11;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int PIX_W       = CH_W * NUM_CH;
  localparam int NUM_ROWS    = 3;
  localparam int SLOT_W      = 2;
  localparam int QUEUE_DEPTH = 4;

  // Window sum of nine 8-bit samples, tap count up to nine.
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int NUM_W       = SUM_W + 1;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic                emit;
    logic                emit_first;
    logic                wr;
    slot_t               wr_slot;
    logic [NUM_ROWS-1:0] row_mask;
    logic                left_ok;
    logic                right_ok;
    logic                last;
    logic [PIX_W-1:0]    pixel;
  } op_t;

  function automatic slot_t next_slot(slot_t s);
    return (s == slot_t'(NUM_ROWS - 1)) ? slot_t'(0) : s + slot_t'(1);
  endfunction

  function automatic slot_t prev_slot(slot_t s);
    return (s == slot_t'(0)) ? slot_t'(NUM_ROWS - 1) : s - slot_t'(1);
  endfunction

  // ceil(2^RECIP_SHIFT / (2 * count)), exact for numerators below 2^NUM_W.
  function automatic logic [RECIP_W-1:0] recip(logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      4'd1:    r = 18'd131072;
      4'd2:    r = 18'd65536;
      4'd3:    r = 18'd43691;
      4'd4:    r = 18'd32768;
      4'd6:    r = 18'd21846;
      4'd9:    r = 18'd14564;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/box_blur_3x3_edge_aware.sv
// 3x3 edge-aware box blur over a raster-order RGB stream.
// Configure image_width (index 0) and image_height (index 1) through the
// write port while the block is idle; each write restarts the frame. Values
// of zero act as one and values above the maximum saturate to it.
// On the slave channel tuser selects a pixel or a drain transaction and tdata
// carries the pixel. Each master transaction is one blurred pixel, with tlast
// on the final pixel of the frame. An output leaves once the pixel below and
// to the right of it has arrived; drain transactions push out what is left.
// Pixels after a complete frame are accepted and dropped.
// The front end takes one transaction per cycle while its four-entry queue
// has room. The back end writes a pixel that only fills the row store, and
// for an output runs three column reads of the row stores, accumulate,
// reciprocal multiply and output register; a pixel that also releases an
// output does both. It handles one queue entry at a time. Reset selects a
// 1x1 frame, empties the queue and clears the output. While the receiver
// stalls the output register holds, the back end waits, the queue fills
// and s_axis_tready falls.
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = bbe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbe_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [bbe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bbe_pkg::PIX_W-1:0]      s_axis_tdata,  // red, green, blue
  input  logic                           s_axis_tuser,  // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [bbe_pkg::PIX_W-1:0]      m_axis_tdata,  // blur_red, blur_green, blur_blue
  output logic                           m_axis_tlast
);

  import bbe_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Q_W   = $bits(op_t) + 2 * COL_W;

  op_t              push_op, pop_op;
  logic [COL_W-1:0] push_wr_col, push_emit_col, pop_wr_col, pop_emit_col;
  logic [Q_W-1:0]   q_in, q_out;
  logic             push, full, pop, empty;

  bbe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .in_pixel_i (s_axis_tdata),
    .push_o     (push),
    .full_i     (full),
    .op_o       (push_op),
    .wr_col_o   (push_wr_col),
    .emit_col_o (push_emit_col)
  );

  assign q_in = {push_op, push_wr_col, push_emit_col};
  assign {pop_op, pop_wr_col, pop_emit_col} = q_out;

  bbe_queue #(
    .DATA_W (Q_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .full_o (full),
    .pop_i  (pop),
    .data_o (q_out),
    .empty_o(empty)
  );

  bbe_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_o      (pop),
    .op_i       (pop_op),
    .wr_col_i   (pop_wr_col),
    .emit_col_i (pop_emit_col),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_data_o   (m_axis_tdata),
    .m_last_o   (m_axis_tlast)
  );

endmodule

// File: hdl/bbe_queue.sv
module bbe_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = bbe_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] data_o,
  output logic              empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("Queue holds more entries than it has room for.");

endmodule

// File: hdl/bbe_front.sv
module bbe_front #(
  parameter int MAX_WIDTH  = bbe_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bbe_pkg::MAX_HEIGHT_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_index_i,
  input  logic [bbe_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_cmd_i,
  input  logic [bbe_pkg::PIX_W-1:0]       in_pixel_i,
  output logic                            push_o,
  input  logic                            full_i,
  output bbe_pkg::op_t                    op_o,
  output logic [COL_W-1:0]                wr_col_o,
  output logic [COL_W-1:0]                emit_col_o
);

  import bbe_pkg::*;

  localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  logic [WID_W-1:0] width_q, width_d;
  logic [HGT_W-1:0] height_q, height_d;
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  slot_t            in_slot_q, in_slot_d, out_slot_q, out_slot_d;
  logic             in_done_q, in_done_d, out_done_q, out_done_d;

  logic [WID_W-1:0] col_inc, ocol_inc;
  logic [HGT_W-1:0] row_inc, orow_inc;
  logic [COL_W-1:0] nxt_col;
  logic [ROW_W-1:0] nxt_row;
  slot_t            nxt_slot;
  logic             nxt_done;
  logic             accept, ready_a, ready_b, emit, wr;
  logic             top_ok, bot_ok, out_wrap, frame_end;
  logic [31:0]      cfg_val;
  logic [WID_W-1:0] cfg_width;
  logic [HGT_W-1:0] cfg_height;

  // An output can leave once the bottom-right pixel of its window has arrived.
  function automatic logic calc_ready(logic [ROW_W-1:0] irow, logic [COL_W-1:0] icol,
                                      logic idone);
    logic [HGT_W-1:0] r1, nr;
    logic [WID_W-1:0] c1, nc;
    r1 = HGT_W'(out_row_q) + HGT_W'(1);
    c1 = WID_W'(out_col_q) + WID_W'(1);
    nr = (r1 < height_q) ? r1 : height_q - HGT_W'(1);
    nc = (c1 < width_q) ? c1 : width_q - WID_W'(1);
    return !out_done_q && (idone || (HGT_W'(irow) > nr) ||
                           ((HGT_W'(irow) == nr) && (WID_W'(icol) > nc)));
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_inc  = WID_W'(in_col_q) + WID_W'(1);
    row_inc  = HGT_W'(in_row_q) + HGT_W'(1);
    nxt_col  = in_col_q;
    nxt_row  = in_row_q;
    nxt_slot = in_slot_q;
    nxt_done = in_done_q;
    if (col_inc >= width_q) begin
      nxt_col  = '0;
      nxt_slot = next_slot(in_slot_q);
      if (row_inc >= height_q) begin
        nxt_row  = '0;
        nxt_done = 1'b1;
      end else begin
        nxt_row = ROW_W'(row_inc);
      end
    end else begin
      nxt_col = COL_W'(col_inc);
    end
  end

  always_comb begin
    ocol_inc  = WID_W'(out_col_q) + WID_W'(1);
    orow_inc  = HGT_W'(out_row_q) + HGT_W'(1);
    out_wrap  = (ocol_inc >= width_q);
    frame_end = out_wrap && (orow_inc >= height_q);
    top_ok    = (out_row_q != '0);
    bot_ok    = (orow_inc < height_q);
  end

  always_comb begin
    ready_a = calc_ready(in_row_q, in_col_q, in_done_q);
    ready_b = calc_ready(nxt_row, nxt_col, nxt_done);
    emit    = 1'b0;
    wr      = 1'b0;
    if (accept) begin
      if (in_cmd_i == CMD_DRAIN) begin
        emit = ready_a;
      end else if (!in_done_q) begin
        wr   = 1'b1;
        emit = ready_a || ready_b;
      end
    end
  end

  always_comb begin
    cfg_val    = 32'(cfg_data_i);
    cfg_width  = (cfg_val == 32'd0) ? WID_W'(1) :
                 (cfg_val > 32'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(cfg_val);
    cfg_height = (cfg_val == 32'd0) ? HGT_W'(1) :
                 (cfg_val > 32'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) : HGT_W'(cfg_val);
  end

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_slot_d  = in_slot_q;
    in_done_d  = in_done_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    out_done_d = out_done_q;
    if (wr) begin
      in_col_d  = nxt_col;
      in_row_d  = nxt_row;
      in_slot_d = nxt_slot;
      in_done_d = nxt_done;
    end
    if (emit) begin
      if (out_wrap) begin
        out_col_d  = '0;
        out_slot_d = next_slot(out_slot_q);
        if (frame_end) begin
          out_row_d  = '0;
          out_done_d = 1'b1;
        end else begin
          out_row_d = ROW_W'(orow_inc);
        end
      end else begin
        out_col_d = COL_W'(ocol_inc);
      end
    end
    if (cfg_we_i) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_slot_d  = '0;
      in_done_d  = 1'b0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_slot_d = '0;
      out_done_d = 1'b0;
      case (cfg_index_i)
        REG_IMAGE_WIDTH:  width_d  = cfg_width;
        REG_IMAGE_HEIGHT: height_d = cfg_height;
        default:          width_d  = width_q;
      endcase
    end
  end

  always_comb begin
    op_o            = '0;
    op_o.emit       = emit;
    op_o.emit_first = ready_a;
    op_o.wr         = wr;
    op_o.wr_slot    = in_slot_q;
    op_o.left_ok    = (out_col_q != '0);
    op_o.right_ok   = (ocol_inc < width_q);
    op_o.last       = frame_end;
    op_o.pixel      = in_pixel_i;
    for (int k = 0; k < NUM_ROWS; k++) begin
      op_o.row_mask[k] = (out_slot_q == slot_t'(k)) ||
                         (top_ok && (prev_slot(out_slot_q) == slot_t'(k))) ||
                         (bot_ok && (next_slot(out_slot_q) == slot_t'(k)));
    end
  end

  assign push_o     = emit || wr;
  assign wr_col_o   = in_col_q;
  assign emit_col_o = out_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WID_W'(1);
      height_q   <= HGT_W'(1);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_done_q  <= 1'b0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
      out_done_q <= 1'b0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      in_done_q  <= in_done_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      out_done_q <= out_done_d;
    end
  end

  a_frame_stays_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_done_q && !cfg_we_i) |=> in_done_q)
    else $error("A received frame was reopened without a configuration write.");

endmodule

// File: hdl/bbe_back.sv
module bbe_back #(
  parameter int MAX_WIDTH = bbe_pkg::MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  output logic                      pop_o,
  input  bbe_pkg::op_t              op_i,
  input  logic [COL_W-1:0]          wr_col_i,
  input  logic [COL_W-1:0]          emit_col_i,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic [bbe_pkg::PIX_W-1:0] m_data_o,
  output logic                      m_last_o
);

  import bbe_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_WR   = 6'b000010,
    S_RD   = 6'b000100,
    S_ACC  = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } back_state_e;

  localparam logic [1:0] RD_LAST = 2'd2;

  back_state_e       state_q, state_d;
  logic [1:0]        rd_cnt_q, rd_cnt_d;
  logic              tap_q, tap_d;
  logic              m_valid_q, m_valid_d;
  op_t               ent_q;
  logic [COL_W-1:0]  wr_col_q, emit_col_q;
  logic [COL_W-1:0]  rd_addr;
  logic [PIX_W-1:0]  rdata_q [NUM_ROWS];
  logic [SUM_W-1:0]  acc_q [NUM_CH];
  logic [SUM_W-1:0]  acc_d [NUM_CH];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PROD_W-1:0] prod_q [NUM_CH];
  logic [PROD_W-1:0] prod_d [NUM_CH];
  logic [NUM_W-1:0]  num [NUM_CH];
  logic [PIX_W-1:0]  m_data_q, m_data_d;
  logic              m_last_q;
  logic              mem_we, out_load, tap_valid;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign mem_we   = (state_q == S_WR);
  assign out_load = (state_q == S_OUT) && (!m_valid_q || m_ready_i);
  assign rd_addr  = emit_col_q - COL_W'(1) + COL_W'(rd_cnt_q);

  always_comb begin
    case (rd_cnt_q)
      2'd0:    tap_valid = ent_q.left_ok;
      RD_LAST: tap_valid = ent_q.right_ok;
      default: tap_valid = 1'b1;
    endcase
  end

  // One row store per slot, so the three rows of a column are read together.
  for (genvar k = 0; k < NUM_ROWS; k++) begin : g_rows
    logic [PIX_W-1:0] line_mem [MAX_WIDTH];

    always_ff @(posedge clk_i) begin
      if (mem_we && ent_q.wr_slot == slot_t'(k)) begin
        line_mem[wr_col_q] <= ent_q.pixel;
      end
      rdata_q[k] <= line_mem[rd_addr];
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      acc_d[c] = acc_q[c];
      if (tap_q) begin
        for (int k = 0; k < NUM_ROWS; k++) begin
          if (ent_q.row_mask[k]) begin
            acc_d[c] = acc_d[c] + SUM_W'(rdata_q[k][c*CH_W +: CH_W]);
          end
        end
      end
      if (state_q == S_IDLE || state_q == S_WR) begin
        acc_d[c] = '0;
      end
      num[c]    = NUM_W'({acc_q[c], 1'b0}) + NUM_W'(cnt_q);
      prod_d[c] = PROD_W'(num[c]) * PROD_W'(recip(cnt_q));
      m_data_d[c*CH_W +: CH_W] = prod_q[c][RECIP_SHIFT +: CH_W];
    end
    cnt_d = cnt_q;
    if (tap_q) begin
      cnt_d = cnt_q + CNT_W'($countones(ent_q.row_mask));
    end
    if (state_q == S_IDLE || state_q == S_WR) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    tap_d    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          if (op_i.emit && (op_i.emit_first || !op_i.wr)) begin
            state_d = S_RD;
          end else if (op_i.wr) begin
            state_d = S_WR;
          end
        end
      end
      S_WR: begin
        state_d = (ent_q.emit && !ent_q.emit_first) ? S_RD : S_IDLE;
      end
      S_RD: begin
        tap_d = tap_valid;
        if (rd_cnt_q == RD_LAST) begin
          rd_cnt_d = '0;
          state_d  = S_ACC;
        end else begin
          rd_cnt_d = rd_cnt_q + 2'd1;
        end
      end
      S_ACC: state_d = S_MUL;
      S_MUL: state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = (ent_q.wr && ent_q.emit_first) ? S_WR : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_cnt_q  <= '0;
      tap_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      tap_q     <= tap_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q      <= op_i;
      wr_col_q   <= wr_col_i;
      emit_col_q <= emit_col_i;
    end
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if (out_load) begin
      m_data_q <= m_data_d;
      m_last_q <= ent_q.last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

  a_tap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (cnt_q == 4'd1 || cnt_q == 4'd2 || cnt_q == 4'd3 ||
                            cnt_q == 4'd4 || cnt_q == 4'd6 || cnt_q == 4'd9))
    else $error("Window tap count is not a possible neighbourhood size.");

  a_acc_after_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> ($past(state_q) == S_RD && $past(rd_cnt_q) == RD_LAST))
    else $error("Accumulation finished before all three columns were read.");

  a_out_from_sequencer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("Output register loaded outside the output step.");

endmodule
